>>> hdl/text_console_char_grid_assert.svh
// assertion macros for the text console character grid
`ifndef TEXT_CONSOLE_CHAR_GRID_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_GRID_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcg_pkg.sv
// shared constants, types and helpers for the text console character grid
`default_nettype none
package tcg_pkg;

  localparam int TEXT_ROWS  = 32;
  localparam int TEXT_COLS  = 80;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int GRID_DEPTH = TEXT_ROWS * TEXT_COLS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W + 1)'(TEXT_ROWS);
  localparam logic [COL_W:0]   COLS_EXT = (COL_W + 1)'(TEXT_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CH_BS           = 8'd8;
  localparam logic [7:0] CH_TAB          = 8'd9;
  localparam logic [7:0] CH_LF           = 8'd10;
  localparam logic [7:0] CH_CR           = 8'd13;
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] PAST_PRINTABLE  = 8'd127;
  localparam logic [7:0] SPACE_BYTE      = 8'd32;

  localparam logic [COL_W:0] TAB_STEP = (COL_W + 1)'(4);
  localparam logic [COL_W:0] TAB_MASK = ~(TAB_STEP - (COL_W + 1)'(1));

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [COL_W-1:0] wr_col;
    logic [7:0]       wr_byte;
    logic [ROW_W-1:0] new_row;
    logic [COL_W-1:0] new_col;
    logic             scroll;
  } put_res_t;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] disp);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, disp};
    if (sum >= ROWS_EXT) begin
      sum = sum - ROWS_EXT;
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(TEXT_COLS);
    return base + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

>>> hdl/tcg_cursor.sv
// character interpreter: next cursor, cell write and scroll for one put request
`default_nettype none
module tcg_cursor (
  input  wire logic [tcg_pkg::ROW_W-1:0] cur_row,
  input  wire logic [tcg_pkg::COL_W-1:0] cur_col,
  input  wire logic [7:0]                char_code,
  output tcg_pkg::put_res_t              res
);

  logic [tcg_pkg::ROW_W:0] row_inc;
  logic [tcg_pkg::COL_W:0] col_inc;
  logic [tcg_pkg::COL_W:0] tab_col;
  logic                    adv;

  always_comb begin
    row_inc     = {1'b0, cur_row} + (tcg_pkg::ROW_W + 1)'(1);
    col_inc     = {1'b0, cur_col} + (tcg_pkg::COL_W + 1)'(1);
    tab_col     = ({1'b0, cur_col} + tcg_pkg::TAB_STEP) & tcg_pkg::TAB_MASK;
    adv         = 1'b0;
    res.wr_en   = 1'b0;
    res.wr_row  = cur_row;
    res.wr_col  = cur_col;
    res.wr_byte = char_code;
    res.new_row = cur_row;
    res.new_col = cur_col;
    res.scroll  = 1'b0;
    case (char_code)
      tcg_pkg::CH_LF: begin
        adv         = 1'b1;
        res.new_col = '0;
      end
      tcg_pkg::CH_CR: begin
        res.new_col = '0;
      end
      tcg_pkg::CH_TAB: begin
        if (tab_col >= tcg_pkg::COLS_EXT) begin
          adv         = 1'b1;
          res.new_col = '0;
        end else begin
          res.new_col = tab_col[tcg_pkg::COL_W-1:0];
        end
      end
      tcg_pkg::CH_BS: begin
        if (cur_col != '0) begin
          res.new_col = cur_col - tcg_pkg::COL_W'(1);
          res.wr_en   = 1'b1;
          res.wr_col  = cur_col - tcg_pkg::COL_W'(1);
          res.wr_byte = tcg_pkg::SPACE_BYTE;
        end
      end
      default: begin
        if (char_code >= tcg_pkg::FIRST_PRINTABLE && char_code < tcg_pkg::PAST_PRINTABLE) begin
          res.wr_en = 1'b1;
          if (col_inc >= tcg_pkg::COLS_EXT) begin
            adv         = 1'b1;
            res.new_col = '0;
          end else begin
            res.new_col = col_inc[tcg_pkg::COL_W-1:0];
          end
        end
      end
    endcase
    if (adv) begin
      if (row_inc >= tcg_pkg::ROWS_EXT) begin
        res.scroll  = 1'b1;
        res.new_row = tcg_pkg::LAST_ROW;
      end else begin
        res.new_row = row_inc[tcg_pkg::ROW_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/text_console_char_grid.sv
// top level: text console grid with ring-pointer scroll over one grid memory
// each request passes the request register, then the result register; cells live in memory
// one request per cycle unless a sweep or held result stalls; cursor, ring pointer in registers
// a put that writes a row blank since reset, clear or scroll first zeroes that row: once that is
// detected, its TEXT_COLS (80) cells are zeroed on the write port; no request accepted meanwhile
// reset clears cursor, ring pointer and row flags; no memory pass, blank rows read as 0
`default_nettype none
`include "text_console_char_grid_assert.svh"
module text_console_char_grid (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero[23:22]
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cursor_row_out[4:0], cursor_col_out[11:5], scrolled[12], cell_value[20:13], zero[23:21]
  output logic [23:0]      out_tdata
);

  localparam int RW = tcg_pkg::ROW_W;
  localparam int CW = tcg_pkg::COL_W;
  localparam int AW = tcg_pkg::ADDR_W;

  // request register
  logic          a_vld_r;
  logic [1:0]    a_mode_r;
  logic [7:0]    a_char_r;
  logic [RW-1:0] a_rrow_r;
  logic [CW-1:0] a_rcol_r;

  // console state
  logic [RW-1:0]                  cur_row_r, cur_row_nxt;
  logic [CW-1:0]                  cur_col_r, cur_col_nxt;
  logic [RW-1:0]                  top_r;
  logic [tcg_pkg::TEXT_ROWS-1:0]  row_vld_r;
  tcg_pkg::state_t                state_r;
  logic [RW-1:0]                  sweep_row_r;
  logic [CW-1:0]                  sweep_col_r;

  // result register
  logic          out_vld_r;
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_col_r;
  logic          out_scr_r;
  logic          out_mem_r;

  // grid memory
  logic [7:0]    grid_mem [tcg_pkg::GRID_DEPTH];
  logic [7:0]    rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  tcg_pkg::put_res_t pr;
  logic [RW-1:0]     wr_phys, rd_phys;
  logic              is_put, is_clear, is_read;
  logic              need_sweep, out_free, a_fire, rd_hit, sweep_done;

  tcg_cursor u_cursor (
    .cur_row   (cur_row_r),
    .cur_col   (cur_col_r),
    .char_code (a_char_r),
    .res       (pr)
  );

  always_comb begin
    is_put     = a_mode_r == tcg_pkg::MODE_PUT;
    is_clear   = a_mode_r == tcg_pkg::MODE_CLEAR;
    is_read    = a_mode_r == tcg_pkg::MODE_READ;
    wr_phys    = tcg_pkg::phys_row(top_r, pr.wr_row);
    rd_phys    = tcg_pkg::phys_row(top_r, a_rrow_r);
    need_sweep = is_put && pr.wr_en && !row_vld_r[wr_phys];
    out_free   = !out_vld_r || out_tready;
    a_fire     = a_vld_r && (state_r == tcg_pkg::ST_RUN) && !need_sweep && out_free;
    rd_hit     = is_read && ({1'b0, a_rrow_r} < tcg_pkg::ROWS_EXT)
                 && ({1'b0, a_rcol_r} < tcg_pkg::COLS_EXT) && row_vld_r[rd_phys];
    sweep_done = (state_r == tcg_pkg::ST_SWEEP) && (sweep_col_r == tcg_pkg::LAST_COL);
    in_tready  = rst_n && (!a_vld_r || a_fire);

    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (is_put) begin
      cur_row_nxt = pr.new_row;
      cur_col_nxt = pr.new_col;
    end else if (is_clear) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
    end

    mem_we    = (state_r == tcg_pkg::ST_SWEEP) || (a_fire && is_put && pr.wr_en);
    mem_waddr = (state_r == tcg_pkg::ST_SWEEP) ? tcg_pkg::cell_addr(sweep_row_r, sweep_col_r)
                                               : tcg_pkg::cell_addr(wr_phys, pr.wr_col);
    mem_wdata = (state_r == tcg_pkg::ST_SWEEP) ? 8'd0 : pr.wr_byte;
    mem_re    = a_fire && rd_hit;
    mem_raddr = tcg_pkg::cell_addr(rd_phys, a_rcol_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_mode_r <= in_tdata[1:0];
      a_char_r <= in_tdata[9:2];
      a_rrow_r <= in_tdata[14:10];
      a_rcol_r <= in_tdata[21:15];
    end
    if (a_fire) begin
      out_row_r <= cur_row_nxt;
      out_col_r <= cur_col_nxt;
      out_scr_r <= is_put && pr.scroll;
      out_mem_r <= rd_hit;
    end
    if (a_vld_r && (state_r == tcg_pkg::ST_RUN) && need_sweep) begin
      sweep_row_r <= wr_phys;
    end
    if (state_r == tcg_pkg::ST_SWEEP) begin
      sweep_col_r <= sweep_col_r + CW'(1);
    end else begin
      sweep_col_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
      row_vld_r <= '0;
      state_r   <= tcg_pkg::ST_RUN;
    end else begin
      if (in_tvalid && in_tready) begin
        a_vld_r <= 1'b1;
      end else if (a_fire) begin
        a_vld_r <= 1'b0;
      end
      if (a_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        tcg_pkg::ST_RUN: begin
          if (a_vld_r && need_sweep) begin
            state_r <= tcg_pkg::ST_SWEEP;
          end
        end
        tcg_pkg::ST_SWEEP: begin
          if (sweep_done) begin
            state_r                <= tcg_pkg::ST_RUN;
            row_vld_r[sweep_row_r] <= 1'b1;
          end
        end
        default: begin
          state_r <= tcg_pkg::ST_RUN;
        end
      endcase
      if (a_fire) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        if (is_put && pr.scroll) begin
          row_vld_r[top_r] <= 1'b0;
          top_r            <= tcg_pkg::phys_row(top_r, RW'(1));
        end else if (is_clear) begin
          row_vld_r <= '0;
          top_r     <= '0;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, (out_mem_r ? rdata_r : 8'd0), out_scr_r, out_col_r, out_row_r};

  `TCG_ASSERT_NOW(a_no_fire_in_sweep, state_r == tcg_pkg::ST_SWEEP, !a_fire, "fire in sweep")
  `TCG_ASSERT_NOW(a_wr_row_vld, a_fire && is_put && pr.wr_en, row_vld_r[wr_phys], "blank row")
  `TCG_ASSERT_NOW(a_col_in_grid, 1'b1, {1'b0, cur_col_r} < tcg_pkg::COLS_EXT, "col past end")
  `TCG_ASSERT_NEXT(a_result_follows, a_fire, out_vld_r, "executed request left no result")
  `TCG_ASSERT_NEXT(a_sweep_marks_row, sweep_done, row_vld_r[$past(sweep_row_r)], "row not marked")

endmodule
`default_nettype wire

>>> verif/text_console_char_grid_test.sv
// self-checking testbench for the text console character grid: shadow grid, cursor and scroll
`default_nettype none
module text_console_char_grid_test;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int TAB_STOP = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 188;
  localparam int RUN_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0] pad;
    logic [6:0] rcol;
    logic [4:0] rrow;
    logic [7:0] ch;
    logic [1:0] mode;
  } request_t;

  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] cell_val;
    logic       scrolled;
    logic [6:0] col;
    logic [4:0] row;
  } report_t;

  class console_mirror;
    logic [7:0] cells [tcg_pkg::TEXT_ROWS][tcg_pkg::TEXT_COLS];
    int cur_row;
    int cur_col;
    int top_line;
    report_t awaited[$];
    int mismatches;

    function new();
      mismatches = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (cells[r, c]) cells[r][c] = 8'h00;
      cur_row = 0;
      cur_col = 0;
      top_line = 0;
    endfunction

    function void note_request(request_t req);
      report_t rep;
      int line;
      rep = '0;
      line = (top_line + cur_row) % tcg_pkg::TEXT_ROWS;
      case (req.mode)
        tcg_pkg::MODE_PUT: begin
          if (req.ch == tcg_pkg::CH_LF) begin
            cur_row++;
            cur_col = 0;
          end else if (req.ch == tcg_pkg::CH_CR) begin
            cur_col = 0;
          end else if (req.ch == tcg_pkg::CH_TAB) begin
            cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
            if (cur_col >= tcg_pkg::TEXT_COLS) begin
              cur_col = 0;
              cur_row++;
            end
          end else if (req.ch == tcg_pkg::CH_BS) begin
            if (cur_col > 0) begin
              cur_col--;
              cells[line][cur_col] = tcg_pkg::SPACE_BYTE;
            end
          end else if (req.ch >= tcg_pkg::FIRST_PRINTABLE
                       && req.ch < tcg_pkg::PAST_PRINTABLE) begin
            cells[line][cur_col] = req.ch;
            cur_col++;
            if (cur_col >= tcg_pkg::TEXT_COLS) begin
              cur_col = 0;
              cur_row++;
            end
          end
          // past the last row: oldest line becomes the cleared bottom line
          if (cur_row >= tcg_pkg::TEXT_ROWS) begin
            for (int c = 0; c < tcg_pkg::TEXT_COLS; c++) cells[top_line][c] = 8'h00;
            top_line = (top_line + 1) % tcg_pkg::TEXT_ROWS;
            cur_row = tcg_pkg::TEXT_ROWS - 1;
            rep.scrolled = 1'b1;
          end
        end
        tcg_pkg::MODE_CLEAR: begin
          blank_screen();
        end
        tcg_pkg::MODE_READ: begin
          if (req.rrow < tcg_pkg::TEXT_ROWS && req.rcol < tcg_pkg::TEXT_COLS) begin
            rep.cell_val = cells[(top_line + req.rrow) % tcg_pkg::TEXT_ROWS][req.rcol];
          end
        end
        default: begin
        end
      endcase
      rep.row = 5'(cur_row);
      rep.col = 7'(cur_col);
      awaited.push_back(rep);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(logic [23:0] word);
      report_t got;
      report_t want;
      got = word;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual %h", $time, word);
        return;
      end
      want = awaited.pop_front();
      compare_field("cursor_row_out", want.row, got.row);
      compare_field("cursor_col_out", want.col, got.col);
      compare_field("scrolled", want.scrolled, got.scrolled);
      compare_field("cell_value", want.cell_val, got.cell_val);
      compare_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  console_mirror board = new();

  text_console_char_grid dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL text_console_char_grid");
    $finish;
  end

  // result side: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_report(out_tdata);
    end
  end

  function automatic request_t console_request(logic [1:0] mode, logic [7:0] ch,
                                               logic [4:0] rr, logic [6:0] rc);
    return '{pad: 2'b00, rcol: rc, rrow: rr, ch: ch, mode: mode};
  endfunction

  task automatic send_request(request_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= req;
    do @(posedge clk); while (!in_tready);
    board.note_request(req);
  endtask

  task automatic await_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    request_t req;
    int pick;
    int sub;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, control bytes, ignored bytes, out-of-grid reads
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, "A", 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::PAST_PRINTABLE - 8'd1,
                                 5'd31, 7'd127));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::SPACE_BYTE, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::FIRST_PRINTABLE - 8'd1,
                                 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::PAST_PRINTABLE, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, 8'hff, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, 8'h00, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::CH_TAB, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::CH_BS, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::CH_CR, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::CH_BS, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, tcg_pkg::CH_LF, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_READ, 8'hff, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'd1));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'd3));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'(tcg_pkg::TEXT_COLS - 1)));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'(tcg_pkg::TEXT_COLS)));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd31, 7'd127));
    send_request(console_request(MODE_SPARE, 8'hff, 5'd31, 7'd127));
    send_request(console_request(tcg_pkg::MODE_CLEAR, 8'hff, 5'd31, 7'd127));
    send_request(console_request(tcg_pkg::MODE_READ, 8'h00, 5'd0, 7'd0));
    send_request(console_request(tcg_pkg::MODE_PUT, "z", 5'd0, 7'd0));
    await_quiet();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 0 && i == 60) begin
          hold_left = HOLD_CYCLES;
        end
        req = 24'($urandom());
        req.pad = 2'b00;
        pick = $urandom_range(999);
        if (pick < 4) begin
          req.mode = tcg_pkg::MODE_CLEAR;
        end else if (pick < 20) begin
          req.mode = MODE_SPARE;
        end else if (pick < 220) begin
          req.mode = tcg_pkg::MODE_READ;
          req.rcol = ($urandom_range(9) == 0) ? 7'($urandom_range(127, tcg_pkg::TEXT_COLS))
                                              : 7'($urandom_range(tcg_pkg::TEXT_COLS - 1));
        end else begin
          req.mode = tcg_pkg::MODE_PUT;
          sub = $urandom_range(99);
          if (sub < 55) begin
            req.ch = 8'($urandom_range(tcg_pkg::PAST_PRINTABLE - 1, tcg_pkg::FIRST_PRINTABLE));
          end else if (sub < 75) begin
            req.ch = tcg_pkg::CH_LF;
          end else if (sub < 80) begin
            req.ch = tcg_pkg::CH_CR;
          end else if (sub < 88) begin
            req.ch = tcg_pkg::CH_TAB;
          end else if (sub < 95) begin
            req.ch = tcg_pkg::CH_BS;
          end
        end
        send_request(req);
      end
      await_quiet();
    end

    if (board.mismatches == 0) begin
      $display("PASS text_console_char_grid");
    end else begin
      $display("FAIL text_console_char_grid");
    end
    $finish;
  end

endmodule
`default_nettype wire
